// ----- src/jlap_pkg.sv -----
package jlap_pkg;

  typedef logic signed [63:0] q32_t;
  typedef logic [5:0] shamt_t;

  localparam q32_t ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic [63:0] CAP_MAG = 64'h4000_0000_0000_0000;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  localparam logic [2:0] REG_POS_GAIN  = 3'd0;
  localparam logic [2:0] REG_DAMP_GAIN = 3'd1;
  localparam logic [2:0] REG_INERTIA   = 3'd2;
  localparam logic [2:0] REG_VEL_WIDTH = 3'd3;

  // per-joint word as it travels down the pipe
  typedef struct packed {
    logic signed [31:0] q;
    logic signed [31:0] v;
    logic signed [31:0] qn;
    logic signed [32:0] n;
    logic signed [32:0] range;
    logic [31:0]        u;
    logic               g_one;
    logic               g_zero;
    logic               s_hi;
    logic               s_lo;
    logic               ov;
    q32_t               s;
    q32_t               rr;
    q32_t               t;
    q32_t               t2;
    q32_t               pd;
    q32_t               v2;
    q32_t               m5;
    q32_t               x;
    q32_t               term;
    q32_t               sum;
    q32_t               au;
    q32_t               al;
    q32_t               m6;
    q32_t               w;
    q32_t               b;
    q32_t               bd;
    q32_t               ib;
    q32_t               a;
    q32_t               m13;
    q32_t               inert;
    q32_t               c;
  } item_t;

endpackage

// ----- src/jlap_mul.sv -----
module jlap_mul #(
  parameter int LANES = 1,
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  jlap_pkg::q32_t   a_i [LANES],
  input  jlap_pkg::q32_t   b_i [LANES],
  input  jlap_pkg::shamt_t sh_i [LANES],
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output jlap_pkg::q32_t   p_o [LANES],
  output logic [LANES-1:0] ov_o,
  output logic [SW-1:0]    side_o
);
  import jlap_pkg::*;

  logic [3:0]       vld_q;
  logic [SW-1:0]    side1_q, side2_q, side3_q, side4_q;
  logic [63:0]      ua_q [LANES];
  logic [63:0]      ub_q [LANES];
  logic [LANES-1:0] neg1_q, neg2_q, neg3_q;
  shamt_t           sh1_q [LANES];
  shamt_t           sh2_q [LANES];
  shamt_t           sh3_q [LANES];
  logic [63:0]      pp_q [LANES][4];
  logic [127:0]     full_q [LANES];
  logic [127:0]     full_d [LANES];
  q32_t             p_q [LANES];
  q32_t             p_d [LANES];
  logic [LANES-1:0] ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      full_d[l] = {64'd0, pp_q[l][0]} + {32'd0, pp_q[l][1], 32'd0}
                + {32'd0, pp_q[l][2], 32'd0} + {pp_q[l][3], 64'd0};
    end
  end

  // shift, saturate at 2^62 on the magnitude, then restore the sign
  always_comb begin
    logic [127:0] shf;
    logic [63:0]  mag;
    for (int l = 0; l < LANES; l++) begin
      shf      = full_q[l] >> sh3_q[l];
      ov_d[l]  = shf > {64'd0, CAP_MAG};
      mag      = ov_d[l] ? CAP_MAG : shf[63:0];
      p_d[l]   = neg3_q[l] ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      neg2_q  <= neg1_q;
      neg3_q  <= neg2_q;
      ov_q    <= ov_d;
      for (int l = 0; l < LANES; l++) begin
        ua_q[l]     <= a_i[l][63] ? 64'(-a_i[l]) : 64'(a_i[l]);
        ub_q[l]     <= b_i[l][63] ? 64'(-b_i[l]) : 64'(b_i[l]);
        neg1_q[l]   <= a_i[l][63] ^ b_i[l][63];
        sh1_q[l]    <= sh_i[l];
        sh2_q[l]    <= sh1_q[l];
        sh3_q[l]    <= sh2_q[l];
        pp_q[l][0]  <= {32'd0, ua_q[l][31:0]} * {32'd0, ub_q[l][31:0]};
        pp_q[l][1]  <= {32'd0, ua_q[l][31:0]} * {32'd0, ub_q[l][63:32]};
        pp_q[l][2]  <= {32'd0, ua_q[l][63:32]} * {32'd0, ub_q[l][31:0]};
        pp_q[l][3]  <= {32'd0, ua_q[l][63:32]} * {32'd0, ub_q[l][63:32]};
        full_q[l]   <= full_d[l];
        p_q[l]      <= p_d[l];
      end
    end
  end

  assign valid_o = vld_q[3];
  assign p_o     = p_q;
  assign ov_o    = ov_q;
  assign side_o  = side4_q;

endmodule

// ----- src/jlap_div.sv -----
module jlap_div #(
  parameter int DW = 32,
  parameter int QW = 49,
  parameter int LANES = 1,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DW+QW-1:0] num_i [LANES],
  input  logic [DW-1:0]   den_i [LANES],
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o [LANES],
  output logic [SW-1:0]   side_o
);

  // one quotient bit per stage, restoring
  logic [DW-1:0] rem_s [QW][LANES];
  logic [QW-1:0] low_s [QW][LANES];
  logic [QW-1:0] quo_s [QW][LANES];
  logic [DW-1:0] den_s [QW][LANES];
  logic [SW-1:0] side_s [QW];
  logic [DW-1:0] rem_d [QW][LANES];
  logic [QW-1:0] quo_d [QW][LANES];
  logic [DW-1:0] rem_q [QW][LANES];
  logic [QW-1:0] low_q [QW][LANES];
  logic [QW-1:0] quo_q [QW][LANES];
  logic [DW-1:0] den_q [QW][LANES];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign side_s[0] = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_s[0][l] = num_i[l][DW+QW-1:QW];
        assign low_s[0][l] = num_i[l][QW-1:0];
        assign quo_s[0][l] = '0;
        assign den_s[0][l] = den_i[l];
      end
    end else begin : g_next
      assign side_s[j] = side_q[j-1];
      assign rem_s[j]  = rem_q[j-1];
      assign low_s[j]  = low_q[j-1];
      assign quo_s[j]  = quo_q[j-1];
      assign den_s[j]  = den_q[j-1];
    end

    always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        trial       = {rem_s[j][l], low_s[j][l][QW-1]};
        ge          = trial >= {1'b0, den_s[j][l]};
        rem_d[j][l] = ge ? DW'(trial - {1'b0, den_s[j][l]}) : trial[DW-1:0];
        quo_d[j][l] = {quo_s[j][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_s[j];
        for (int l = 0; l < LANES; l++) begin
          rem_q[j][l] <= rem_d[j][l];
          low_q[j][l] <= low_s[j][l] << 1;
          quo_q[j][l] <= quo_d[j][l];
          den_q[j][l] <= den_s[j][l];
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ----- src/joint_limit_avoidance_policy_core.sv -----
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   joint_position_i .. neutral_position_i
// out      output     out_valid_o/out_ready_i inertia_o, force_res_o, status_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one joint word enters per cycle while the output is not stalled; the pipe depth is set by the two
// bit-per-stage dividers, the thirteen-step exp series and the chained multiplier units
// reset clears all valid bits and loads the register defaults; no clearing pass
// a stall on the output freezes the whole pipe in place and drops in_ready_o with it
module joint_limit_avoidance_policy_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] joint_position_i,
  input  logic signed [31:0] joint_velocity_i,
  input  logic signed [31:0] upper_limit_i,
  input  logic signed [31:0] lower_limit_i,
  input  logic signed [31:0] neutral_position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        inertia_o,
  output logic signed [31:0] force_res_o,
  output logic [1:0]         status_o
);
  import jlap_pkg::*;

  localparam int IW  = $bits(item_t);
  localparam int QW1 = 33 + FRACTION_BITS;
  localparam int NW1 = 32 + QW1;
  localparam logic [NW1-1:0] NUM_R = NW1'(1) << (32 + FRACTION_BITS);
  localparam shamt_t SH_F  = shamt_t'(FRACTION_BITS);
  localparam shamt_t SH_32 = 6'd32;
  localparam q32_t FMAX = 64'sd2147483647;
  localparam q32_t FMIN = -64'sd2147483648;

  logic        en;
  logic [31:0] kp_q, kd_q, lam_q, sg_q;

  item_t it0_q;
  logic  v0_q;

  // stage signals
  item_t            d1_in, it1, it2, it3, it4, it5, it6, it7, it8, itf;
  logic [NW1-1:0]   d1_num [3];
  logic [31:0]      d1_den [3];
  logic [QW1-1:0]   d1_quo [3];
  logic [IW-1:0]    d1_side;
  logic             d1_vld;

  q32_t             g0_a [6];
  q32_t             g0_b [6];
  shamt_t           g0_sh [6];
  q32_t             g0_p [6];
  logic [5:0]       g0_ov;
  logic [IW-1:0]    g0_side;
  logic             g0_vld;

  logic [IW-1:0]    ser_side [14];
  logic [13:0]      ser_vld;
  logic [IW-1:0]    sq_side [6];
  logic [5:0]       sq_vld;

  q32_t             p1_a [3];
  q32_t             p1_b [3];
  shamt_t           p1_sh [3];
  q32_t             p1_p [3];
  logic [2:0]       p1_ov;
  logic [IW-1:0]    p1_side;
  logic             p1_vld;

  q32_t             p2_a [2];
  q32_t             p2_b [2];
  shamt_t           p2_sh [2];
  q32_t             p2_p [2];
  logic [1:0]       p2_ov;
  logic [IW-1:0]    p2_side;
  logic             p2_vld;

  logic [125:0]     d2_num [1];
  logic [62:0]      d2_den [1];
  logic [62:0]      d2_quo [1];
  logic [IW-1:0]    d2_side;
  logic             d2_vld;

  q32_t             p3_a [2];
  q32_t             p3_b [2];
  shamt_t           p3_sh [2];
  q32_t             p3_p [2];
  logic [1:0]       p3_ov;
  logic [IW-1:0]    p3_side;
  logic             p3_vld;

  q32_t             p4_a [2];
  q32_t             p4_b [2];
  shamt_t           p4_sh [2];
  q32_t             p4_p [2];
  logic [1:0]       p4_ov;
  logic [IW-1:0]    p4_side;
  logic             p4_vld;

  q32_t             p5_a [2];
  q32_t             p5_b [2];
  shamt_t           p5_sh [2];
  q32_t             p5_p [2];
  logic [1:0]       p5_ov;
  logic [IW-1:0]    p5_side;
  logic             p5_vld;

  logic             out_valid_q;
  logic [30:0]      inertia_q, inertia_d;
  logic [31:0]      force_q, force_d;
  logic [1:0]       status_q, status_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= 32'd65536;
      kd_q  <= 32'd65536;
      lam_q <= 32'd65536;
      sg_q  <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POS_GAIN:  kp_q  <= cfg_data_i;
        REG_DAMP_GAIN: kd_q  <= cfg_data_i;
        REG_INERTIA:   lam_q <= cfg_data_i;
        REG_VEL_WIDTH: sg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      it0_q       <= '0;
      it0_q.q     <= joint_position_i;
      it0_q.v     <= joint_velocity_i;
      it0_q.qn    <= neutral_position_i;
      it0_q.range <= 33'(upper_limit_i) - 33'(lower_limit_i);
      it0_q.n     <= 33'(joint_position_i) - 33'(lower_limit_i);
      it0_q.u     <= joint_velocity_i[31] ? 32'(-joint_velocity_i) : joint_velocity_i;
    end
  end

  // position fraction, velocity ratio and slope reciprocal share one divider
  always_comb begin
    logic signed [35:0] r4, r5, m;
    d1_in        = it0_q;
    r4           = 36'(it0_q.range) <<< 2;
    r5           = r4 + 36'(it0_q.range);
    m            = 36'(it0_q.n) + r4;
    d1_in.s_hi   = 36'(it0_q.n) >= r5;
    d1_in.s_lo   = 36'(it0_q.n) < -r4;
    d1_in.g_one  = it0_q.u == 32'd0;
    d1_in.g_zero = (it0_q.u != 32'd0) && ({3'd0, it0_q.u} >= {sg_q, 3'd0});
    d1_num[0]    = NW1'({m[35:0], 32'd0});
    d1_den[0]    = it0_q.range[31:0];
    d1_num[1]    = NW1'({it0_q.u, 32'd0});
    d1_den[1]    = sg_q;
    d1_num[2]    = NUM_R;
    d1_den[2]    = it0_q.range[31:0];
  end

  jlap_div #(.DW(32), .QW(QW1), .LANES(3), .SW(IW)) u_div_frac (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q),
    .num_i(d1_num), .den_i(d1_den), .side_i(d1_in),
    .valid_o(d1_vld), .quo_o(d1_quo), .side_o(d1_side)
  );

  always_comb begin
    q32_t rho;
    it1 = item_t'(d1_side);
    if (it1.s_lo) begin
      it1.s = -(ONE_Q32 <<< 2);
    end else if (it1.s_hi) begin
      it1.s = (ONE_Q32 <<< 2) + ONE_Q32;
    end else begin
      it1.s = $signed({28'd0, d1_quo[0][35:0]}) - (ONE_Q32 <<< 2);
    end
    it1.t  = ONE_Q32 - (it1.s <<< 1);
    it1.rr = $signed(64'(d1_quo[2]));
    rho    = $signed({29'd0, d1_quo[1][34:0]});
    g0_a[0] = rho;                        g0_b[0] = rho;                  g0_sh[0] = 6'd33;
    g0_a[1] = it1.t;                      g0_b[1] = it1.t;                g0_sh[1] = SH_32;
    g0_a[2] = $signed(64'(kp_q));         g0_b[2] = q32_t'(it1.qn) - q32_t'(it1.q);
    g0_sh[2] = SH_F;
    g0_a[3] = $signed(64'(kd_q));         g0_b[3] = q32_t'(it1.v);        g0_sh[3] = SH_F;
    g0_a[4] = q32_t'(it1.v);              g0_b[4] = q32_t'(it1.v);        g0_sh[4] = SH_F;
    g0_a[5] = it1.rr;                     g0_b[5] = it1.t;                g0_sh[5] = SH_32;
  end

  jlap_mul #(.LANES(6), .SW(IW)) u_mul_g0 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_vld),
    .a_i(g0_a), .b_i(g0_b), .sh_i(g0_sh), .side_i(it1),
    .valid_o(g0_vld), .p_o(g0_p), .ov_o(g0_ov), .side_o(g0_side)
  );

  always_comb begin
    it2      = item_t'(g0_side);
    it2.x    = g0_p[0];
    it2.t2   = g0_p[1];
    it2.pd   = g0_p[2] - g0_p[3];
    it2.v2   = g0_p[4];
    it2.m5   = g0_p[5];
    it2.term = ONE_Q32;
    it2.sum  = ONE_Q32;
    it2.ov   = it2.ov | (|g0_ov[5:1]);
  end

  assign ser_side[0] = it2;
  assign ser_vld[0]  = g0_vld;

  // exp series of -x/32, one term per step, division by k through its reciprocal
  for (genvar i = 0; i < 13; i++) begin : g_series
    localparam int K = i + 1;
    localparam logic [63:0] RECIP = ((64'd1 << 40) + 64'(K) - 64'd1) / 64'(K);
    item_t         it_a, it_b;
    q32_t          ma_a [1];
    q32_t          ma_b [1];
    shamt_t        ma_sh [1];
    q32_t          ma_p [1];
    logic [IW-1:0] ma_side;
    logic          ma_vld;
    q32_t          mb_a [1];
    q32_t          mb_b [1];
    shamt_t        mb_sh [1];
    q32_t          mb_p [1];
    logic [IW-1:0] mb_side;
    logic          mb_vld;

    always_comb begin
      it_a     = item_t'(ser_side[i]);
      ma_a[0]  = it_a.term;
      ma_b[0]  = it_a.x;
      ma_sh[0] = 6'd37;
    end

    jlap_mul #(.LANES(1), .SW(IW)) u_mul_pow (
      .clk_i, .rst_ni, .en_i(en), .valid_i(ser_vld[i]),
      .a_i(ma_a), .b_i(ma_b), .sh_i(ma_sh), .side_i(ser_side[i]),
      .valid_o(ma_vld), .p_o(ma_p), .ov_o(), .side_o(ma_side)
    );

    assign mb_a[0]  = ma_p[0];
    assign mb_b[0]  = $signed(RECIP);
    assign mb_sh[0] = 6'd40;

    jlap_mul #(.LANES(1), .SW(IW)) u_mul_fact (
      .clk_i, .rst_ni, .en_i(en), .valid_i(ma_vld),
      .a_i(mb_a), .b_i(mb_b), .sh_i(mb_sh), .side_i(ma_side),
      .valid_o(mb_vld), .p_o(mb_p), .ov_o(), .side_o(mb_side)
    );

    always_comb begin
      it_b      = item_t'(mb_side);
      it_b.term = mb_p[0];
      it_b.sum  = ((K % 2) == 1) ? it_b.sum - mb_p[0] : it_b.sum + mb_p[0];
    end

    assign ser_side[i+1] = it_b;
    assign ser_vld[i+1]  = mb_vld;
  end

  assign sq_side[0] = ser_side[13];
  assign sq_vld[0]  = ser_vld[13];

  // five squarings undo the divide by 32
  for (genvar j = 0; j < 5; j++) begin : g_square
    item_t         it_s, it_o;
    q32_t          ms_a [1];
    shamt_t        ms_sh [1];
    q32_t          ms_p [1];
    logic [IW-1:0] ms_side;
    logic          ms_vld;

    always_comb begin
      it_s     = item_t'(sq_side[j]);
      ms_sh[0] = SH_32;
      if (it_s.sum < 0) begin
        ms_a[0] = '0;
      end else if (it_s.sum > ONE_Q32) begin
        ms_a[0] = ONE_Q32;
      end else begin
        ms_a[0] = it_s.sum;
      end
    end

    jlap_mul #(.LANES(1), .SW(IW)) u_mul_sq (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld[j]),
      .a_i(ms_a), .b_i(ms_a), .sh_i(ms_sh), .side_i(sq_side[j]),
      .valid_o(ms_vld), .p_o(ms_p), .ov_o(), .side_o(ms_side)
    );

    always_comb begin
      it_o     = item_t'(ms_side);
      it_o.sum = ms_p[0];
    end

    assign sq_side[j+1] = it_o;
    assign sq_vld[j+1]  = ms_vld;
  end

  // velocity gates
  always_comb begin
    q32_t gs, g;
    it3 = item_t'(sq_side[5]);
    if (it3.g_one) begin
      gs = ONE_Q32;
    end else if (it3.g_zero) begin
      gs = '0;
    end else begin
      gs = it3.sum;
    end
    g      = ONE_Q32 - gs;
    it3.au = (!it3.v[31] && it3.v != 32'sd0) ? g : '0;
    it3.al = it3.v[31] ? g : '0;
    p1_a[0] = it3.au;            p1_b[0] = it3.s;            p1_sh[0] = SH_32;
    p1_a[1] = it3.al;            p1_b[1] = ONE_Q32 - it3.s;  p1_sh[1] = SH_32;
    p1_a[2] = it3.au - it3.al;   p1_b[2] = it3.t;            p1_sh[2] = SH_32;
  end

  jlap_mul #(.LANES(3), .SW(IW)) u_mul_p1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld[5]),
    .a_i(p1_a), .b_i(p1_b), .sh_i(p1_sh), .side_i(it3),
    .valid_o(p1_vld), .p_o(p1_p), .ov_o(p1_ov), .side_o(p1_side)
  );

  always_comb begin
    it4     = item_t'(p1_side);
    it4.w   = p1_p[0] + p1_p[1];
    it4.m6  = p1_p[2];
    it4.ov  = it4.ov | (|p1_ov);
    p2_a[0] = it4.w;             p2_b[0] = it4.t2;                          p2_sh[0] = SH_32;
    p2_a[1] = it4.m5;            p2_b[1] = (ONE_Q32 <<< 2) - it4.m6;        p2_sh[1] = SH_32;
  end

  jlap_mul #(.LANES(2), .SW(IW)) u_mul_p2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p1_vld),
    .a_i(p2_a), .b_i(p2_b), .sh_i(p2_sh), .side_i(it4),
    .valid_o(p2_vld), .p_o(p2_p), .ov_o(p2_ov), .side_o(p2_side)
  );

  // barrier and its reciprocal
  always_comb begin
    it5       = item_t'(p2_side);
    it5.b     = ONE_Q32 - p2_p[0];
    it5.bd    = p2_p[1];
    it5.ov    = it5.ov | (|p2_ov);
    d2_num[0] = 126'd1 << 64;
    d2_den[0] = it5.b[62:0];
  end

  jlap_div #(.DW(63), .QW(63), .LANES(1), .SW(IW)) u_div_recip (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p2_vld),
    .num_i(d2_num), .den_i(d2_den), .side_i(it5),
    .valid_o(d2_vld), .quo_o(d2_quo), .side_o(d2_side)
  );

  always_comb begin
    it6     = item_t'(d2_side);
    it6.ib  = $signed({1'b0, d2_quo[0]});
    p3_a[0] = it6.ib;            p3_b[0] = it6.ib;           p3_sh[0] = SH_32;
    p3_a[1] = it6.bd;            p3_b[1] = it6.ib;           p3_sh[1] = SH_32;
  end

  jlap_mul #(.LANES(2), .SW(IW)) u_mul_p3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_vld),
    .a_i(p3_a), .b_i(p3_b), .sh_i(p3_sh), .side_i(it6),
    .valid_o(p3_vld), .p_o(p3_p), .ov_o(p3_ov), .side_o(p3_side)
  );

  always_comb begin
    it7     = item_t'(p3_side);
    it7.a   = p3_p[0];
    it7.m13 = p3_p[1];
    it7.ov  = it7.ov | (|p3_ov);
    p4_a[0] = $signed(64'(lam_q)); p4_b[0] = it7.a;          p4_sh[0] = SH_32;
    p4_a[1] = it7.m13;             p4_b[1] = it7.a;          p4_sh[1] = SH_32;
  end

  jlap_mul #(.LANES(2), .SW(IW)) u_mul_p4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p3_vld),
    .a_i(p4_a), .b_i(p4_b), .sh_i(p4_sh), .side_i(it7),
    .valid_o(p4_vld), .p_o(p4_p), .ov_o(p4_ov), .side_o(p4_side)
  );

  always_comb begin
    it8       = item_t'(p4_side);
    it8.inert = p4_p[0];
    it8.c     = p4_p[1];
    it8.ov    = it8.ov | (|p4_ov);
    p5_a[0] = it8.inert;         p5_b[0] = it8.pd;           p5_sh[0] = SH_F;
    p5_a[1] = it8.c;             p5_b[1] = it8.v2;           p5_sh[1] = SH_32;
  end

  jlap_mul #(.LANES(2), .SW(IW)) u_mul_p5 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p4_vld),
    .a_i(p5_a), .b_i(p5_b), .sh_i(p5_sh), .side_i(it8),
    .valid_o(p5_vld), .p_o(p5_p), .ov_o(p5_ov), .side_o(p5_side)
  );

  // result select and saturation
  always_comb begin
    q32_t f;
    logic ov;
    itf = item_t'(p5_side);
    f   = p5_p[0] + p5_p[1];
    ov  = itf.ov | (|p5_ov);
    if (itf.range <= 33'sd0) begin
      inertia_d = '0;
      force_d   = '0;
      status_d  = STATUS_ORDER;
    end else if (itf.b < 64'sd4) begin
      // barrier gone: push back toward the inside
      inertia_d = 31'h7FFF_FFFF;
      force_d   = (itf.t <= 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      status_d  = STATUS_SAT;
    end else begin
      if (itf.inert > FMAX) begin
        inertia_d = 31'h7FFF_FFFF;
        ov        = 1'b1;
      end else begin
        inertia_d = itf.inert[30:0];
      end
      if (f > FMAX) begin
        force_d = 32'h7FFF_FFFF;
        ov      = 1'b1;
      end else if (f < FMIN) begin
        force_d = 32'h8000_0000;
        ov      = 1'b1;
      end else begin
        force_d = f[31:0];
      end
      status_d = ov ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p5_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inertia_q <= inertia_d;
      force_q   <= force_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inertia_o   = inertia_q;
  assign force_res_o = $signed(force_q);
  assign status_o    = status_q;

endmodule
